### rtl/core/dsdq_pkg.sv
// ----------------------------------------------------------------------------
// Depth-sorted draw queue package
// Shared types and constants for the sorted draw queue core and its cells.
// ----------------------------------------------------------------------------
package dsdq_pkg;

  // Default number of entries (one cell per entry).
  localparam int CAPACITY_DEF = 64;

  // Request function codes.
  localparam logic FUNC_ADD   = 1'b0;
  localparam logic FUNC_DRAIN = 1'b1;

  typedef enum logic [1:0] {
    ST_ACCEPTED = 2'd0,
    ST_FULL     = 2'd1,
    ST_DRAINED  = 2'd2,
    ST_EMPTY    = 2'd3
  } status_t;

  typedef struct packed {
    logic        func;
    logic [15:0] sprite_handle;
    logic [15:0] depth;
  } req_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] sprite_handle_res;
    logic [15:0] depth_res;
    logic        last;
  } res_t;

  // One stored queue entry.
  typedef struct packed {
    logic [15:0] handle;
    logic [15:0] depth;
  } entry_t;

  // Per-cycle command broadcast to every cell.
  typedef struct packed {
    logic insert;  // sorted insert of the broadcast entry
    logic shift;   // move every entry one place toward the front
  } cell_ctrl_t;

endpackage

### rtl/core/dsdq_cell.sv
// ----------------------------------------------------------------------------
// Depth-sorted draw queue cell
// Holds one queue entry and trades it with its neighbors on insert and drain.
// ----------------------------------------------------------------------------
module dsdq_cell (
  input  logic                clk,
  input  dsdq_pkg::cell_ctrl_t ctrl,
  input  dsdq_pkg::entry_t    new_entry,
  input  logic                occupied,
  input  logic                greater_prev,
  input  dsdq_pkg::entry_t    entry_prev,
  input  dsdq_pkg::entry_t    entry_following,
  output logic                greater,
  output dsdq_pkg::entry_t    entry
);

  // The new entry belongs at or before this cell when this cell is empty or
  // holds a strictly smaller depth. Along the sorted chain this flag is a
  // run of zeros followed by a run of ones.
  assign greater = !occupied || (new_entry.depth > entry.depth);

  always_ff @(posedge clk) begin
    if (ctrl.insert) begin
      if (greater && !greater_prev) begin
        entry <= new_entry;
      end else if (greater) begin
        entry <= entry_prev;
      end
    end else if (ctrl.shift) begin
      entry <= entry_following;
    end
  end

endmodule

### rtl/core/depth_sorted_draw_queue_core.sv
// ----------------------------------------------------------------------------
// Depth-sorted draw queue core
// Bounded queue of sprite entries kept in descending depth order.
// ----------------------------------------------------------------------------
// Usage: requests arrive on req (req_valid/req_ready) and results leave on res
// (res_valid/res_ready). An add request inserts its handle and depth in front
// of the first stored entry of strictly smaller depth, so equal depths keep
// their arrival order, and returns one result: accepted, or full when all
// CAPACITY cells are occupied (the entry is then dropped). A drain request
// returns every stored entry front to back, one result per cycle while res_ready
// is high, with last set on the final one, and leaves the queue empty; a drain
// of an empty queue returns one empty result.
// The result of an add or of an empty drain is loaded into the output register
// when the request is taken, and adds may follow back to back while res_ready
// is high. A drain of a non-empty queue first enters the drain state, then
// passes each entry in turn through the single output register that the front
// cell feeds; no request is taken until it has finished.
// Reset clears the entry count, the control state and the output valid; the
// cells themselves are not cleared. When the receiver stalls, the pending
// result holds in the output register and the block stops taking requests or
// draining entries.
// ----------------------------------------------------------------------------
module depth_sorted_draw_queue_core #(
  parameter int CAPACITY = dsdq_pkg::CAPACITY_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_ready,
  input  dsdq_pkg::req_t  req,
  output logic            res_valid,
  input  logic            res_ready,
  output dsdq_pkg::res_t  res
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  typedef enum logic {
    S_IDLE,
    S_DRAIN
  } state_t;

  state_t                    state;
  logic [CNT_W-1:0]          count;
  logic                      out_free;
  logic                      req_fire;
  logic                      is_full;
  dsdq_pkg::cell_ctrl_t      ctrl;
  dsdq_pkg::entry_t          new_entry;
  dsdq_pkg::entry_t          cell_entry [CAPACITY];
  logic [CAPACITY-1:0]       cell_greater;

  // The output register can take a result this cycle.
  assign out_free  = !res_valid || res_ready;
  assign req_ready = (state == S_IDLE) && out_free;
  assign req_fire  = req_valid && req_ready;
  assign is_full   = (count == CNT_W'(CAPACITY));

  assign new_entry.handle = req.sprite_handle;
  assign new_entry.depth  = req.depth;

  // Inserts happen only for accepted adds on a queue with room; a drain
  // shifts the chain one place toward the front as each result is loaded.
  assign ctrl.insert = req_fire && (req.func == dsdq_pkg::FUNC_ADD) && !is_full;
  assign ctrl.shift  = (state == S_DRAIN) && out_free;

  // The chain of cells. Cell 0 is the front of the queue. On insert each cell
  // looks at its predecessor's compare flag to decide between loading the new
  // entry, taking its predecessor's entry, or holding.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic             greater_prev;
    dsdq_pkg::entry_t entry_prev;
    dsdq_pkg::entry_t entry_following;

    if (i == 0) begin : g_front
      assign greater_prev = 1'b0;
      assign entry_prev   = '0;
    end else begin : g_inner
      assign greater_prev = cell_greater[i-1];
      assign entry_prev   = cell_entry[i-1];
    end

    if (i == CAPACITY - 1) begin : g_back
      assign entry_following = '0;
    end else begin : g_fwd
      assign entry_following = cell_entry[i+1];
    end

    dsdq_cell u_cell (
      .clk             (clk),
      .ctrl            (ctrl),
      .new_entry       (new_entry),
      .occupied        (CNT_W'(i) < count),
      .greater_prev    (greater_prev),
      .entry_prev      (entry_prev),
      .entry_following (entry_following),
      .greater         (cell_greater[i]),
      .entry           (cell_entry[i])
    );
  end

  // Control state, entry count and the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      res_valid <= 1'b0;
    end else begin
      if (res_valid && res_ready) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_fire) begin
            res_valid             <= 1'b1;
            res.sprite_handle_res <= '0;
            res.depth_res         <= '0;
            res.last              <= 1'b1;
            if (req.func == dsdq_pkg::FUNC_ADD) begin
              if (is_full) begin
                res.status <= dsdq_pkg::ST_FULL;
              end else begin
                res.status <= dsdq_pkg::ST_ACCEPTED;
                count      <= count + CNT_W'(1);
              end
            end else if (count == '0) begin
              res.status <= dsdq_pkg::ST_EMPTY;
            end else begin
              // The drain results follow in the drain state, starting from the front cell.
              res_valid <= 1'b0;
              state     <= S_DRAIN;
            end
          end
        end
        S_DRAIN: begin
          if (out_free) begin
            res_valid             <= 1'b1;
            res.status            <= dsdq_pkg::ST_DRAINED;
            res.sprite_handle_res <= cell_entry[0].handle;
            res.depth_res         <= cell_entry[0].depth;
            res.last              <= (count == CNT_W'(1));
            count                 <= count - CNT_W'(1);
            if (count == CNT_W'(1)) begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // The entry count never passes the number of cells.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("entry count exceeds capacity");

  // An add on a full queue leaves the count unchanged.
  a_full_drop: assert property (@(posedge clk) disable iff (rst)
    (req_fire && req.func == dsdq_pkg::FUNC_ADD && is_full) |=> (count == $past(count)))
    else $error("full add changed the entry count");

  // Leaving the drain state coincides with the final result being loaded.
  a_drain_last: assert property (@(posedge clk) disable iff (rst)
    ($past(state) == S_DRAIN && state == S_IDLE) |-> (res_valid && res.last && count == '0))
    else $error("drain ended without a final result");

  // No request is taken while draining.
  a_drain_block: assert property (@(posedge clk) disable iff (rst)
    (state == S_DRAIN) |-> !req_ready)
    else $error("request taken during drain");

endmodule

### sim/tb.sv
// ----------------------------------------------------------------------------
// Depth-sorted draw queue testbench
// Sends add and drain requests to the queue core. Both sides stall at random.
// A software copy of the queue predicts every result, and each returned
// result is checked against it field by field, in order.
// ----------------------------------------------------------------------------
module tb;

  localparam int QCAP       = dsdq_pkg::CAPACITY_DEF;
  localparam int CYCLE_CAP  = 200000;
  localparam int REPORT_CAP = 10;

  logic           clk       = 1'b0;
  logic           rst       = 1'b1;
  logic           req_valid = 1'b0;
  logic           res_ready = 1'b0;
  dsdq_pkg::req_t req       = '0;
  logic           req_ready;
  logic           res_valid;
  dsdq_pkg::res_t res;

  // Software view of the queue contents, front first.
  dsdq_pkg::entry_t draw_list[$];
  // Results that are still owed by the block, oldest first.
  dsdq_pkg::res_t   pending_results[$];

  int req_idle_pct  = 0;
  int res_stall_pct = 0;
  int error_count   = 0;
  int cycle_count   = 0;
  dsdq_pkg::res_t want;

  depth_sorted_draw_queue_core #(
    .CAPACITY(QCAP)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res      (res)
  );

  always #6 clk = ~clk;

  // Run guard. A correct run is far shorter than this.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_CAP) begin
      $display("tb: errors");
      $finish;
    end
  end

  // Receiver back-pressure.
  always @(posedge clk) begin
    res_ready <= ($urandom_range(99) >= res_stall_pct);
  end

  task automatic flag_error(input string what);
    error_count++;
    if (error_count <= REPORT_CAP) begin
      $display("%0t: %s", $time, what);
    end
  endtask

  // Appends one expected result at the tail of the owed list.
  function automatic void owe_result(input dsdq_pkg::res_t x);
    pending_results.insert(pending_results.size(), x);
  endfunction

  // Works out the results of one accepted request and updates the queue copy.
  function automatic void predict_draw_results(input dsdq_pkg::req_t r);
    dsdq_pkg::res_t   x;
    dsdq_pkg::entry_t e;
    int               pos;
    int               n;
    x      = '0;
    x.last = 1'b1;
    n      = draw_list.size();
    if (r.func == dsdq_pkg::FUNC_ADD) begin
      if (n >= QCAP) begin
        x.status = dsdq_pkg::ST_FULL;
      end else begin
        // Insert ahead of the first strictly shallower entry; ties go behind.
        pos = n;
        for (int i = 0; i < n; i++) begin
          if (r.depth > draw_list[i].depth) begin
            pos = i;
            break;
          end
        end
        e.handle = r.sprite_handle;
        e.depth  = r.depth;
        draw_list.insert(pos, e);
        x.status = dsdq_pkg::ST_ACCEPTED;
      end
      owe_result(x);
    end else if (n == 0) begin
      x.status = dsdq_pkg::ST_EMPTY;
      owe_result(x);
    end else begin
      for (int i = 0; i < n; i++) begin
        x.status            = dsdq_pkg::ST_DRAINED;
        x.sprite_handle_res = draw_list[i].handle;
        x.depth_res         = draw_list[i].depth;
        x.last              = (i == n - 1);
        owe_result(x);
      end
      draw_list.delete();
    end
  endfunction

  // Result checker: every accepted result is matched against the oldest
  // prediction.
  always @(posedge clk) begin
    if (!rst && res_valid && res_ready) begin
      if (pending_results.size() == 0) begin
        flag_error($sformatf("unexpected result %p", res));
      end else begin
        want = pending_results.pop_front();
        if (res.status !== want.status)
          flag_error($sformatf("status: want %s got %0d", want.status.name(), res.status));
        if (res.sprite_handle_res !== want.sprite_handle_res)
          flag_error($sformatf("handle: want %h got %h", want.sprite_handle_res,
                               res.sprite_handle_res));
        if (res.depth_res !== want.depth_res)
          flag_error($sformatf("depth: want %h got %h", want.depth_res, res.depth_res));
        if (res.last !== want.last)
          flag_error($sformatf("last: want %b got %b", want.last, res.last));
      end
    end
  end

  // Sends one request. Valid stays high from one request to the next unless
  // the sender decides to idle first.
  task automatic push_request(input dsdq_pkg::req_t r);
    while ($urandom_range(99) < req_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= r;
    do @(posedge clk); while (!req_ready);
    predict_draw_results(r);
  endtask

  task automatic send_add(input logic [15:0] h, input logic [15:0] d);
    dsdq_pkg::req_t r;
    r.func          = dsdq_pkg::FUNC_ADD;
    r.sprite_handle = h;
    r.depth         = d;
    push_request(r);
  endtask

  task automatic send_drain(input logic [15:0] h, input logic [15:0] d);
    dsdq_pkg::req_t r;
    r.func          = dsdq_pkg::FUNC_DRAIN;
    r.sprite_handle = h;
    r.depth         = d;
    push_request(r);
  endtask

  // A random 16-bit value.
  function automatic logic [15:0] rand16();
    return 16'($urandom_range(16'hFFFF));
  endfunction

  // Depth keys drawn from a few styles so that ties and extremes are common.
  function automatic logic [15:0] pick_depth();
    case ($urandom_range(3))
      0:       return 16'($urandom_range(3));
      1:       return $urandom_range(1) ? 16'hFFFF : 16'h0000;
      2:       return 16'h8000 + 16'($urandom_range(3));
      default: return rand16();
    endcase
  endfunction

  // Extremes of every field, ties at front and tail, empty drains, and a
  // drain whose ignored fields are all ones.
  task automatic test_directed();
    send_drain(16'h0000, 16'h0000);
    send_add(16'h0000, 16'h0000);
    send_add(16'hFFFF, 16'hFFFF);
    send_add(16'h1234, 16'h8000);
    send_add(16'h5678, 16'h8000);
    send_add(16'hAAAA, 16'h0000);
    send_add(16'h5555, 16'hFFFF);
    send_add(16'h0F0F, 16'h7FFF);
    send_add(16'hF0F0, 16'h8001);
    send_drain(16'hFFFF, 16'hFFFF);
    send_drain(16'h0000, 16'h0000);
    send_add(16'hBEEF, 16'h4242);
    send_drain(16'h0000, 16'h0000);
    send_add(16'h0001, 16'h0001);
    send_add(16'h0002, 16'h0002);
    send_drain(16'h0000, 16'h0000);
  endtask

  // Fills the queue, pushes past capacity, then drains it all.
  task automatic test_fill_and_overflow();
    for (int i = 0; i < QCAP + 3; i++) begin
      send_add(rand16(), pick_depth());
    end
    send_drain(rand16(), rand16());
    send_add(rand16(), pick_depth());
    send_drain(16'h0000, 16'h0000);
  endtask

  // Mostly bursts of adds closed by a drain; the rest is loose single
  // requests that may leave entries behind for the next burst.
  task automatic test_random_bursts(input int n_items);
    int             sent;
    int             burst;
    dsdq_pkg::req_t r;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(9) == 0) begin
        r.func          = 1'($urandom_range(1));
        r.sprite_handle = rand16();
        r.depth         = pick_depth();
        push_request(r);
        sent++;
      end else begin
        burst = $urandom_range(1, 10);
        if ($urandom_range(7) == 0) burst = $urandom_range(11, 40);
        repeat (burst) send_add(rand16(), pick_depth());
        send_drain(rand16(), rand16());
        sent += burst + 1;
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    req_idle_pct  = 34;
    res_stall_pct = 55;
    test_directed();
    test_fill_and_overflow();

    req_idle_pct  = 55;
    res_stall_pct = 34;
    test_random_bursts(90);

    req_idle_pct  = 0;
    res_stall_pct = 0;
    test_random_bursts(90);

    req_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    // Let any stray result show up before the verdict.
    repeat (QCAP + 10) @(posedge clk);

    if (error_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

### depth_sorted_draw_queue_core.f
rtl/core/dsdq_pkg.sv
rtl/core/dsdq_cell.sv
rtl/core/depth_sorted_draw_queue_core.sv
sim/tb.sv
